>>> rtl/tsfm_pkg.sv
// Shared types, constants and helpers for the TCP session flow meter.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package tsfm_pkg;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'h06;
  localparam logic [7:0]  FLAGS_SYN      = 8'h02;
  localparam logic [7:0]  FLAGS_FIN_ACK  = 8'h11;

  localparam logic [7:0]  OVERHEAD_RESET = 8'd16;
  localparam logic [2:0]  ADDR_OVERHEAD  = 3'd0;

  localparam int unsigned MICROS_PER_SECOND = 1000000;
  localparam int unsigned BPS_SCALE         = 8000000;

  localparam int unsigned TIME_W = 52;
  localparam int unsigned QUOT_W = 55;
  localparam int unsigned STEP_W = $clog2(QUOT_W + 1);

  localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

  typedef struct packed {
    logic [31:0] session_number;
    logic [31:0] server_address;
    logic [31:0] client_address;
    logic [15:0] server_port;
    logic [15:0] client_port;
    logic [31:0] packet_total;
    logic [31:0] byte_total;
    logic [31:0] payload_total;
    logic [31:0] start_seconds;
    logic [19:0] start_micros;
    logic [31:0] end_seconds;
    logic [19:0] end_micros;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/tsfm_front.sv
// Front end: classifies each packet item, tracks the session and its counters,
// and emits a statistics job for every matching FIN+ACK. Depends on tsfm_pkg.
`default_nettype none

module tsfm_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire logic [7:0]        overhead,
  input  wire logic [15:0]       ethertype,
  input  wire logic [7:0]        ip_protocol,
  input  wire logic [7:0]        tcp_flag_bits,
  input  wire logic [3:0]        ip_header_words,
  input  wire logic [3:0]        tcp_offset_words,
  input  wire logic [31:0]       source_address,
  input  wire logic [31:0]       dest_address,
  input  wire logic [15:0]       source_port,
  input  wire logic [15:0]       dest_port,
  input  wire logic [15:0]       frame_length,
  input  wire logic [31:0]       stamp_seconds,
  input  wire logic [19:0]       stamp_micros,
  output logic                   push,
  output tsfm_pkg::job_t         push_job
);
  import tsfm_pkg::*;

  logic        session_open;
  logic [31:0] session_counter;
  logic [31:0] held_client_address;
  logic [31:0] held_server_address;
  logic [15:0] held_client_port;
  logic [15:0] held_server_port;
  logic [31:0] start_seconds;
  logic [19:0] start_micros;
  logic [31:0] packet_counter;
  logic [31:0] byte_counter;
  logic [31:0] payload_counter;

  logic        pkt_ok;
  logic        is_syn;
  logic        is_fin;
  logic        from_server;
  logic [8:0]  hdr_len;
  logic [15:0] payload_len;

  always_comb begin
    pkt_ok      = (ethertype == ETHERTYPE_IPV4) && (ip_protocol == PROTO_TCP);
    is_syn      = (tcp_flag_bits == FLAGS_SYN);
    is_fin      = (tcp_flag_bits == FLAGS_FIN_ACK);
    from_server = session_open &&
                  (source_address == held_server_address) &&
                  (dest_address == held_client_address) &&
                  (source_port == held_server_port) &&
                  (dest_port == held_client_port);
    hdr_len     = 9'({ip_header_words, 2'b00}) + 9'({tcp_offset_words, 2'b00}) +
                  9'(overhead);
    payload_len = (frame_length > 16'(hdr_len)) ? frame_length - 16'(hdr_len) : 16'd0;
    push        = accept && pkt_ok && !is_syn && from_server && is_fin;
  end

  always_comb begin
    push_job.session_number = session_counter;
    push_job.server_address = held_server_address;
    push_job.client_address = held_client_address;
    push_job.server_port    = held_server_port;
    push_job.client_port    = held_client_port;
    push_job.packet_total   = packet_counter;
    push_job.byte_total     = byte_counter;
    push_job.payload_total  = payload_counter;
    push_job.start_seconds  = start_seconds;
    push_job.start_micros   = start_micros;
    push_job.end_seconds    = stamp_seconds;
    push_job.end_micros     = stamp_micros;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      session_open        <= 1'b0;
      session_counter     <= '0;
      held_client_address <= '0;
      held_server_address <= '0;
      held_client_port    <= '0;
      held_server_port    <= '0;
      start_seconds       <= '0;
      start_micros        <= '0;
      packet_counter      <= '0;
      byte_counter        <= '0;
      payload_counter     <= '0;
    end else if (accept && pkt_ok) begin
      if (is_syn) begin
        session_counter     <= sat_add32(session_counter, 32'd1);
        packet_counter      <= '0;
        byte_counter        <= '0;
        payload_counter     <= '0;
        held_client_address <= source_address;
        held_server_address <= dest_address;
        held_client_port    <= source_port;
        held_server_port    <= dest_port;
        start_seconds       <= stamp_seconds;
        start_micros        <= stamp_micros;
        session_open        <= 1'b1;
      end else if (from_server && !is_fin) begin
        packet_counter  <= sat_add32(packet_counter, 32'd1);
        byte_counter    <= sat_add32(byte_counter, 32'(frame_length));
        payload_counter <= sat_add32(payload_counter, 32'(payload_len));
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/tsfm_queue.sv
// Short job queue between the front end and the rate calculator.
// Depends on tsfm_pkg for the job and status types.
`default_nettype none

module tsfm_queue #(
  parameter int unsigned DEPTH = tsfm_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire tsfm_pkg::job_t    push_job,
  input  wire logic              pop,
  output tsfm_pkg::job_t         pop_job,
  output tsfm_pkg::q_stat_t      stat
);
  import tsfm_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  always_comb begin
    stat.full  = (count == CW'(DEPTH));
    stat.empty = (count == '0);
    pop_job    = entries[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/tsfm_back.sv
// Back end: turns one statistics job into a result item, computing the
// duration and both bit rates with a one-bit-per-cycle divider. Depends on tsfm_pkg.
`default_nettype none

module tsfm_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire tsfm_pkg::q_stat_t stat,
  input  wire tsfm_pkg::job_t    pop_job,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [31:0]            session_number,
  output logic [31:0]            server_address,
  output logic [31:0]            client_address,
  output logic [15:0]            server_port,
  output logic [15:0]            client_port,
  output logic [31:0]            packet_total,
  output logic [31:0]            byte_total,
  output logic [31:0]            payload_total,
  output logic [51:0]            duration_micros,
  output logic [54:0]            throughput_bps,
  output logic [54:0]            goodput_bps
);
  import tsfm_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_SUM  = 6'b000100,
    ST_SUB  = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  state_t              state;
  state_t              state_next;
  job_t                job;
  logic [TIME_W-1:0]   prod0;
  logic [TIME_W-1:0]   prod1;
  logic [TIME_W-1:0]   t0;
  logic [TIME_W-1:0]   t1;
  logic [TIME_W-1:0]   dur;
  logic [TIME_W-1:0]   rem_b;
  logic [TIME_W-1:0]   rem_p;
  logic [QUOT_W-1:0]   quo_b;
  logic [QUOT_W-1:0]   quo_p;
  logic [STEP_W-1:0]   step;
  logic [TIME_W:0]     trial_b;
  logic [TIME_W:0]     trial_p;
  logic                ge_b;
  logic                ge_p;

  always_comb begin
    trial_b = {rem_b, quo_b[QUOT_W-1]};
    trial_p = {rem_p, quo_p[QUOT_W-1]};
    ge_b    = (trial_b >= {1'b0, dur});
    ge_p    = (trial_p >= {1'b0, dur});
  end

  always_comb begin
    pop        = (state == ST_IDLE) && !stat.empty;
    state_next = state;
    case (state)
      ST_IDLE: if (!stat.empty) state_next = ST_MUL;
      ST_MUL:  state_next = ST_SUM;
      ST_SUM:  state_next = ST_SUB;
      ST_SUB:  state_next = ST_DIV;
      ST_DIV:  if (step == '0) state_next = ST_DONE;
      ST_DONE: if (out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // With a zero duration every quotient bit comes out set, which is the
  // saturated all-ones rate.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (!stat.empty) job <= pop_job;
      end
      ST_MUL: begin
        prod0 <= TIME_W'(job.start_seconds) * TIME_W'(MICROS_PER_SECOND);
        prod1 <= TIME_W'(job.end_seconds) * TIME_W'(MICROS_PER_SECOND);
        quo_b <= QUOT_W'(job.byte_total) * QUOT_W'(BPS_SCALE);
        quo_p <= QUOT_W'(job.payload_total) * QUOT_W'(BPS_SCALE);
      end
      ST_SUM: begin
        t0 <= prod0 + TIME_W'(job.start_micros);
        t1 <= prod1 + TIME_W'(job.end_micros);
      end
      ST_SUB: begin
        dur   <= (t1 > t0) ? t1 - t0 : '0;
        rem_b <= '0;
        rem_p <= '0;
        step  <= STEP_W'(QUOT_W - 1);
      end
      ST_DIV: begin
        rem_b <= ge_b ? TIME_W'(trial_b - {1'b0, dur}) : TIME_W'(trial_b);
        rem_p <= ge_p ? TIME_W'(trial_p - {1'b0, dur}) : TIME_W'(trial_p);
        quo_b <= {quo_b[QUOT_W-2:0], ge_b};
        quo_p <= {quo_p[QUOT_W-2:0], ge_p};
        step  <= step - 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid       = (state == ST_DONE);
    session_number  = job.session_number;
    server_address  = job.server_address;
    client_address  = job.client_address;
    server_port     = job.server_port;
    client_port     = job.client_port;
    packet_total    = job.packet_total;
    byte_total      = job.byte_total;
    payload_total   = job.payload_total;
    duration_micros = dur;
    throughput_bps  = quo_b;
    goodput_bps     = quo_p;
  end

endmodule

`default_nettype wire

>>> rtl/tcp_session_flow_meter.sv
// TCP session flow meter: packet items are accepted one per cycle while the job
// queue has room; counters update in the cycle of acceptance. A matching FIN+ACK
// gives its result item after the back end's multiply, sum, subtract and 55-bit
// divide states; the back end takes the next queued job only once it is idle again.
// Synchronous reset clears the session, counters and queue; the overhead register returns to 16.
`default_nettype none

module tcp_session_flow_meter #(
  parameter int unsigned QUEUE_DEPTH = tsfm_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] ethertype,
  input  wire logic [7:0]  ip_protocol,
  input  wire logic [7:0]  tcp_flag_bits,
  input  wire logic [3:0]  ip_header_words,
  input  wire logic [3:0]  tcp_offset_words,
  input  wire logic [31:0] source_address,
  input  wire logic [31:0] dest_address,
  input  wire logic [15:0] source_port,
  input  wire logic [15:0] dest_port,
  input  wire logic [15:0] frame_length,
  input  wire logic [31:0] stamp_seconds,
  input  wire logic [19:0] stamp_micros,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      session_number,
  output logic [31:0]      server_address,
  output logic [31:0]      client_address,
  output logic [15:0]      server_port,
  output logic [15:0]      client_port,
  output logic [31:0]      packet_total,
  output logic [31:0]      byte_total,
  output logic [31:0]      payload_total,
  output logic [51:0]      duration_micros,
  output logic [54:0]      throughput_bps,
  output logic [54:0]      goodput_bps
);
  import tsfm_pkg::*;

  logic       frame_overhead;
  logic [7:0] overhead;
  logic       accept;
  logic       push;
  logic       pop;
  job_t       push_job;
  job_t       pop_job;
  q_stat_t    q_stat;

  assign frame_overhead = (paddr == ADDR_OVERHEAD);
  assign pready         = 1'b1;
  assign prdata         = frame_overhead ? {24'd0, overhead} : 32'd0;
  assign in_ready       = !q_stat.full;
  assign accept         = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      overhead <= OVERHEAD_RESET;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      overhead <= pwdata[7:0];
    end
  end

  tsfm_front u_front (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .overhead         (overhead),
    .ethertype        (ethertype),
    .ip_protocol      (ip_protocol),
    .tcp_flag_bits    (tcp_flag_bits),
    .ip_header_words  (ip_header_words),
    .tcp_offset_words (tcp_offset_words),
    .source_address   (source_address),
    .dest_address     (dest_address),
    .source_port      (source_port),
    .dest_port        (dest_port),
    .frame_length     (frame_length),
    .stamp_seconds    (stamp_seconds),
    .stamp_micros     (stamp_micros),
    .push             (push),
    .push_job         (push_job)
  );

  tsfm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .stat     (q_stat)
  );

  tsfm_back u_back (
    .clk             (clk),
    .rst             (rst),
    .stat            (q_stat),
    .pop_job         (pop_job),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .session_number  (session_number),
    .server_address  (server_address),
    .client_address  (client_address),
    .server_port     (server_port),
    .client_port     (client_port),
    .packet_total    (packet_total),
    .byte_total      (byte_total),
    .payload_total   (payload_total),
    .duration_micros (duration_micros),
    .throughput_bps  (throughput_bps),
    .goodput_bps     (goodput_bps)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    !(push && q_stat.full))
    else $error("job pushed into a full queue");

  a_pop_needs_job: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("job popped from an empty queue");

  a_no_pop_while_showing: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !pop)
    else $error("new job taken while a result item is pending");

  a_pop_leads_to_work: assert property (@(posedge clk) disable iff (rst)
    pop |=> !out_valid && !pop)
    else $error("back end skipped its computation");

endmodule

`default_nettype wire

>>> verif/tcp_session_flow_meter_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for tcp_session_flow_meter: drives packet header items and APB
// writes, predicts the session statistics per item, and checks every result item.
// Depends on rtl/tsfm_pkg.sv and rtl/tcp_session_flow_meter.sv.

module tcp_session_flow_meter_tb;
  import tsfm_pkg::*;

  typedef struct packed {
    logic [15:0] ethertype;
    logic [7:0]  ip_protocol;
    logic [7:0]  tcp_flag_bits;
    logic [3:0]  ip_header_words;
    logic [3:0]  tcp_offset_words;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [15:0] frame_length;
    logic [31:0] stamp_seconds;
    logic [19:0] stamp_micros;
  } header_item_t;

  typedef struct packed {
    logic [31:0] session_number;
    logic [31:0] server_address;
    logic [31:0] client_address;
    logic [15:0] server_port;
    logic [15:0] client_port;
    logic [31:0] packet_total;
    logic [31:0] byte_total;
    logic [31:0] payload_total;
    logic [51:0] duration_micros;
    logic [54:0] throughput_bps;
    logic [54:0] goodput_bps;
  } flow_stats_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic         in_valid = 1'b0;
  logic         in_ready;
  header_item_t drv_pkt = '0;
  logic         out_valid;
  logic         out_ready = 1'b0;

  logic [31:0] session_number;
  logic [31:0] server_address;
  logic [31:0] client_address;
  logic [15:0] server_port;
  logic [15:0] client_port;
  logic [31:0] packet_total;
  logic [31:0] byte_total;
  logic [31:0] payload_total;
  logic [51:0] duration_micros;
  logic [54:0] throughput_bps;
  logic [54:0] goodput_bps;

  header_item_t header_backlog[$];
  flow_stats_t  stats_due[$];
  flow_stats_t  due_stats;

  int error_count = 0;
  int tcp_items = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // Predictor state.
  logic [7:0]  overhead = OVERHEAD_RESET;
  logic        open_flag = 1'b0;
  logic [31:0] opened_count = '0;
  logic [31:0] client_ip = '0;
  logic [31:0] server_ip = '0;
  logic [15:0] client_tcp_port = '0;
  logic [15:0] server_tcp_port = '0;
  logic [31:0] syn_sec = '0;
  logic [19:0] syn_us = '0;
  logic [31:0] pkt_count = '0;
  logic [31:0] octet_count = '0;
  logic [31:0] payload_count = '0;

  tcp_session_flow_meter u_dut (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .ethertype        (drv_pkt.ethertype),
    .ip_protocol      (drv_pkt.ip_protocol),
    .tcp_flag_bits    (drv_pkt.tcp_flag_bits),
    .ip_header_words  (drv_pkt.ip_header_words),
    .tcp_offset_words (drv_pkt.tcp_offset_words),
    .source_address   (drv_pkt.source_address),
    .dest_address     (drv_pkt.dest_address),
    .source_port      (drv_pkt.source_port),
    .dest_port        (drv_pkt.dest_port),
    .frame_length     (drv_pkt.frame_length),
    .stamp_seconds    (drv_pkt.stamp_seconds),
    .stamp_micros     (drv_pkt.stamp_micros),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .session_number   (session_number),
    .server_address   (server_address),
    .client_address   (client_address),
    .server_port      (server_port),
    .client_port      (client_port),
    .packet_total     (packet_total),
    .byte_total       (byte_total),
    .payload_total    (payload_total),
    .duration_micros  (duration_micros),
    .throughput_bps   (throughput_bps),
    .goodput_bps      (goodput_bps)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void note_error(input string what, input logic [63:0] want,
                                     input logic [63:0] got);
    error_count++;
    if (error_count <= 10) begin
      $display("%0t: %s: expected %0h, got %0h", $realtime, what, want, got);
    end
  endfunction

  function automatic void check_field(input string what, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      note_error(what, want, got);
    end
  endfunction

  function automatic logic [31:0] add_clamped(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] total;
    total = {1'b0, a} + {1'b0, b};
    return total[32] ? 32'hFFFF_FFFF : total[31:0];
  endfunction

  function automatic logic [54:0] bit_rate(input logic [31:0] amount, input logic [63:0] span);
    logic [63:0] quot;
    if (span == 64'd0) begin
      return '1;
    end
    quot = (64'(amount) * 64'(BPS_SCALE)) / span;
    return quot[54:0];
  endfunction

  function automatic void meter_packet(input header_item_t p);
    logic [63:0] stamp0;
    logic [63:0] stamp1;
    logic [63:0] span;
    logic [31:0] hdr;
    logic [31:0] pay;
    flow_stats_t r;
    if (p.ethertype != ETHERTYPE_IPV4 || p.ip_protocol != PROTO_TCP) begin
      return;
    end
    if (p.tcp_flag_bits == FLAGS_SYN) begin
      if (opened_count != 32'hFFFF_FFFF) begin
        opened_count = opened_count + 32'd1;
      end
      pkt_count = '0;
      octet_count = '0;
      payload_count = '0;
      client_ip = p.source_address;
      server_ip = p.dest_address;
      client_tcp_port = p.source_port;
      server_tcp_port = p.dest_port;
      syn_sec = p.stamp_seconds;
      syn_us = p.stamp_micros;
      open_flag = 1'b1;
      return;
    end
    if (!(open_flag && p.source_address == server_ip && p.dest_address == client_ip &&
          p.source_port == server_tcp_port && p.dest_port == client_tcp_port)) begin
      return;
    end
    if (p.tcp_flag_bits == FLAGS_FIN_ACK) begin
      stamp0 = 64'(syn_sec) * 64'(MICROS_PER_SECOND) + 64'(syn_us);
      stamp1 = 64'(p.stamp_seconds) * 64'(MICROS_PER_SECOND) + 64'(p.stamp_micros);
      span = (stamp1 > stamp0) ? stamp1 - stamp0 : 64'd0;
      r.session_number = opened_count;
      r.server_address = server_ip;
      r.client_address = client_ip;
      r.server_port = server_tcp_port;
      r.client_port = client_tcp_port;
      r.packet_total = pkt_count;
      r.byte_total = octet_count;
      r.payload_total = payload_count;
      r.duration_micros = span[51:0];
      r.throughput_bps = bit_rate(octet_count, span);
      r.goodput_bps = bit_rate(payload_count, span);
      stats_due.push_back(r);
    end else begin
      hdr = 32'(p.ip_header_words) * 32'd4 + 32'(p.tcp_offset_words) * 32'd4 + 32'(overhead);
      pay = (32'(p.frame_length) > hdr) ? 32'(p.frame_length) - hdr : 32'd0;
      pkt_count = add_clamped(pkt_count, 32'd1);
      octet_count = add_clamped(octet_count, 32'(p.frame_length));
      payload_count = add_clamped(payload_count, pay);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        meter_packet(drv_pkt);
      end
      if (!in_valid || in_ready) begin
        if (header_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          drv_pkt <= header_backlog.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (stats_due.size() == 0) begin
          note_error("result item with none pending", 64'd0, 64'(session_number));
        end else begin
          due_stats = stats_due.pop_front();
          check_field("session_number", due_stats.session_number, session_number);
          check_field("server_address", due_stats.server_address, server_address);
          check_field("client_address", due_stats.client_address, client_address);
          check_field("server_port", due_stats.server_port, server_port);
          check_field("client_port", due_stats.client_port, client_port);
          check_field("packet_total", due_stats.packet_total, packet_total);
          check_field("byte_total", due_stats.byte_total, byte_total);
          check_field("payload_total", due_stats.payload_total, payload_total);
          check_field("duration_micros", due_stats.duration_micros, duration_micros);
          check_field("throughput_bps", due_stats.throughput_bps, throughput_bps);
          check_field("goodput_bps", due_stats.goodput_bps, goodput_bps);
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  function automatic logic [19:0] rand_micros();
    if ($urandom_range(0, 9) == 0) begin
      return 20'($urandom_range(0, 20'hFFFFF));
    end
    return 20'($urandom_range(0, 999999));
  endfunction

  function automatic logic [15:0] rand_len();
    if ($urandom_range(0, 99) < 85) begin
      return 16'($urandom_range(0, 1600));
    end
    return 16'($urandom);
  endfunction

  function automatic logic [7:0] data_flags();
    logic [7:0] f;
    f = 8'($urandom);
    if (f == FLAGS_SYN || f == FLAGS_FIN_ACK) begin
      f = 8'h18;
    end
    return f;
  endfunction

  function automatic header_item_t tcp_item(input logic [7:0] flags,
      input logic [31:0] sa, input logic [15:0] sp, input logic [31:0] da,
      input logic [15:0] dp, input logic [15:0] len, input logic [3:0] ihl,
      input logic [3:0] toff, input logic [31:0] sec, input logic [19:0] us);
    header_item_t p;
    p.ethertype = ETHERTYPE_IPV4;
    p.ip_protocol = PROTO_TCP;
    p.tcp_flag_bits = flags;
    p.ip_header_words = ihl;
    p.tcp_offset_words = toff;
    p.source_address = sa;
    p.dest_address = da;
    p.source_port = sp;
    p.dest_port = dp;
    p.frame_length = len;
    p.stamp_seconds = sec;
    p.stamp_micros = us;
    return p;
  endfunction

  function automatic header_item_t rand_item(input logic [7:0] flags,
      input logic [31:0] sa, input logic [15:0] sp, input logic [31:0] da,
      input logic [15:0] dp);
    return tcp_item(flags, sa, sp, da, dp, rand_len(), 4'($urandom_range(0, 15)),
                    4'($urandom_range(0, 15)), $urandom, rand_micros());
  endfunction

  function automatic void queue_item(input header_item_t p);
    header_backlog.push_back(p);
    if (p.ethertype == ETHERTYPE_IPV4 && p.ip_protocol == PROTO_TCP) begin
      tcp_items++;
    end
  endfunction

  task automatic fin_stamp(input logic [31:0] s0, input logic [19:0] u0,
                           output logic [31:0] s1, output logic [19:0] u1);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      s1 = s0 + 32'($urandom_range(0, 4));
      u1 = rand_micros();
    end else if (pick < 80) begin
      s1 = s0;
      u1 = u0;
    end else if (pick < 90) begin
      s1 = s0 - 32'd1;
      u1 = rand_micros();
    end else begin
      s1 = $urandom;
      u1 = rand_micros();
    end
  endtask

  task automatic queue_fin(input logic [31:0] ca, input logic [15:0] cp,
                           input logic [31:0] sa, input logic [15:0] sp,
                           input logic [31:0] s0, input logic [19:0] u0);
    header_item_t p;
    logic [31:0] s1;
    logic [19:0] u1;
    fin_stamp(s0, u0, s1, u1);
    p = rand_item(FLAGS_FIN_ACK, sa, sp, ca, cp);
    p.stamp_seconds = s1;
    p.stamp_micros = u1;
    queue_item(p);
  endtask

  task automatic queue_session();
    header_item_t p;
    logic [31:0] ca;
    logic [31:0] sa;
    logic [15:0] cp;
    logic [15:0] sp;
    logic [31:0] s0;
    logic [19:0] u0;
    int unsigned n;
    int unsigned pick;
    ca = $urandom;
    sa = $urandom;
    cp = 16'($urandom);
    sp = 16'($urandom);
    s0 = $urandom;
    u0 = rand_micros();
    p = rand_item(FLAGS_SYN, ca, cp, sa, sp);
    p.stamp_seconds = s0;
    p.stamp_micros = u0;
    queue_item(p);
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 16);
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        queue_item(rand_item(data_flags(), sa, sp, ca, cp));
      end else if (pick < 70) begin
        queue_item(rand_item(data_flags(), ca, cp, sa, sp));
      end else if (pick < 80) begin
        p = rand_item($urandom_range(0, 1) ? FLAGS_SYN : data_flags(), sa, sp, ca, cp);
        if ($urandom_range(0, 1)) begin
          p.ethertype = 16'($urandom);
        end else begin
          p.ip_protocol = 8'($urandom);
        end
        queue_item(p);
      end else if (pick < 88) begin
        p = rand_item($urandom_range(0, 1) ? FLAGS_FIN_ACK : data_flags(), sa, sp, ca, cp);
        case ($urandom_range(0, 3))
          0: p.source_address = p.source_address ^ (32'd1 << $urandom_range(0, 31));
          1: p.dest_address = p.dest_address ^ (32'd1 << $urandom_range(0, 31));
          2: p.source_port = p.source_port ^ (16'd1 << $urandom_range(0, 15));
          default: p.dest_port = p.dest_port ^ (16'd1 << $urandom_range(0, 15));
        endcase
        queue_item(p);
      end else if (pick < 94) begin
        queue_fin(ca, cp, sa, sp, s0, u0);
      end else begin
        queue_item(rand_item(FLAGS_FIN_ACK, ca, cp, sa, sp));
      end
    end
    if ($urandom_range(0, 9) != 0) begin
      queue_fin(ca, cp, sa, sp, s0, u0);
      if ($urandom_range(0, 4) == 0) begin
        queue_item(rand_item(data_flags(), sa, sp, ca, cp));
        queue_fin(ca, cp, sa, sp, s0, u0);
      end
    end
  endtask

  task automatic queue_sessions(input int target);
    tcp_items = 0;
    while (tcp_items < target) begin
      queue_session();
    end
  endtask

  task automatic drain();
    while (header_backlog.size() != 0 || in_valid) begin
      @(negedge clk);
    end
    while (stats_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (80) @(negedge clk);
  endtask

  task automatic set_overhead(input logic [7:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_OVERHEAD;
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    overhead = value;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    psel <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    if (prdata !== 32'(value)) begin
      note_error("frame_overhead readback", 64'(value), 64'(prdata));
    end
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    header_item_t p;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 22;
    recv_stall_pct = 57;
    @(negedge clk);

    // Nothing may count or emit before the first SYN, even with the all-zero reset tuple.
    queue_item(tcp_item(FLAGS_FIN_ACK, 32'h0, 16'h0, 32'h0, 16'h0, 16'd60, 4'd5, 4'd5,
                        32'd10, 20'd0));
    queue_item(tcp_item(8'h10, 32'h0, 16'h0, 32'h0, 16'h0, 16'd1500, 4'd5, 4'd5,
                        32'd10, 20'd0));
    p = tcp_item(FLAGS_SYN, 32'h0, 16'h0, 32'h0, 16'h0, 16'd60, 4'd5, 4'd5, 32'd0, 20'd0);
    p.ethertype = 16'h86DD;
    queue_item(p);
    queue_item(tcp_item(FLAGS_SYN, 32'hFFFF_FFFF, 16'hFFFF, 32'h0, 16'h0, 16'd0, 4'd15,
                        4'd15, 32'hFFFF_FFFF, 20'd999999));
    queue_item(tcp_item(8'h10, 32'h0, 16'h0, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 4'd0, 4'd0,
                        32'd0, 20'd0));
    queue_item(tcp_item(8'h12, 32'h0, 16'h0, 32'hFFFF_FFFF, 16'hFFFF, 16'd100, 4'd15,
                        4'd15, 32'd0, 20'd0));
    p = tcp_item(8'h10, 32'h0, 16'h0, 32'hFFFF_FFFF, 16'hFFFF, 16'd500, 4'd5, 4'd5,
                 32'd0, 20'd0);
    p.ethertype = 16'hFFFF;
    queue_item(p);
    p.ethertype = ETHERTYPE_IPV4;
    p.ip_protocol = 8'h11;
    queue_item(p);
    queue_item(tcp_item(8'h10, 32'hFFFF_FFFF, 16'hFFFF, 32'h0, 16'h0, 16'd700, 4'd5, 4'd5,
                        32'd0, 20'd0));
    queue_item(tcp_item(FLAGS_FIN_ACK, 32'h0, 16'h0, 32'hFFFF_FFFF, 16'hFFFE, 16'd60,
                        4'd5, 4'd5, 32'hFFFF_FFFF, 20'hFFFFF));
    queue_item(tcp_item(FLAGS_FIN_ACK, 32'h0, 16'h0, 32'hFFFF_FFFF, 16'hFFFF, 16'd60,
                        4'd5, 4'd5, 32'hFFFF_FFFF, 20'hFFFFF));
    queue_item(tcp_item(FLAGS_FIN_ACK, 32'h0, 16'h0, 32'hFFFF_FFFF, 16'hFFFF, 16'd60,
                        4'd5, 4'd5, 32'hFFFF_FFFF, 20'hFFFFF));
    queue_item(tcp_item(8'hFF, 32'h0, 16'h0, 32'hFFFF_FFFF, 16'hFFFF, 16'd0, 4'd0, 4'd0,
                        32'd0, 20'd0));
    queue_item(tcp_item(FLAGS_FIN_ACK, 32'h0, 16'h0, 32'hFFFF_FFFF, 16'hFFFF, 16'd60,
                        4'd5, 4'd5, 32'd0, 20'd0));
    drain();

    queue_item(tcp_item(FLAGS_SYN, 32'h0A00_0001, 16'd1234, 32'hC0A8_0001, 16'd80, 16'd60,
                        4'd5, 4'd5, 32'd0, 20'd0));
    queue_item(tcp_item(FLAGS_FIN_ACK, 32'hC0A8_0001, 16'd80, 32'h0A00_0001, 16'd1234,
                        16'd60, 4'd5, 4'd5, 32'd0, 20'd0));
    queue_item(tcp_item(8'h00, 32'hC0A8_0001, 16'd80, 32'h0A00_0001, 16'd1234, 16'hFFFF,
                        4'd5, 4'd5, 32'd0, 20'd5));
    queue_item(tcp_item(8'h18, 32'hC0A8_0001, 16'd80, 32'h0A00_0001, 16'd1234, 16'd1500,
                        4'd5, 4'd8, 32'd0, 20'd9));
    queue_item(tcp_item(FLAGS_FIN_ACK, 32'hC0A8_0001, 16'd80, 32'h0A00_0001, 16'd1234,
                        16'd60, 4'd5, 4'd5, 32'd1, 20'd0));
    queue_item(tcp_item(FLAGS_FIN_ACK, 32'hC0A8_0001, 16'd80, 32'h0A00_0001, 16'd1234,
                        16'd60, 4'd5, 4'd5, 32'hFFFF_FFFF, 20'd999999));
    queue_item(tcp_item(FLAGS_FIN_ACK, 32'h0A00_0001, 16'd1234, 32'hC0A8_0001, 16'd80,
                        16'd60, 4'd5, 4'd5, 32'd2, 20'd0));
    drain();

    set_overhead(8'hFF);
    queue_sessions(600);
    drain();

    send_idle_pct = 57;
    recv_stall_pct = 22;
    set_overhead(8'h00);
    queue_sessions(600);
    drain();

    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_overhead(8'($urandom_range(1, 254)));
    queue_sessions(600);
    drain();

    error_count += stats_due.size();
    if (error_count == 0) begin
      $display("tcp_session_flow_meter_tb: clean");
    end else begin
      $display("tcp_session_flow_meter_tb: errors");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("tcp_session_flow_meter_tb: errors");
    $finish;
  end

endmodule
